FILE: rtl/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// Types, widths and index constants shared by the segment intersection
// pipeline.
// ----------------------------------------------------------------------------
package sip_pkg;

   // Coordinate width and every width that follows from it.
   localparam int COORD_W    = 16;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int CROSS_W    = PROD_W + 1;
   localparam int SPLIT_W    = (CROSS_W + 1) / 2;
   localparam int HI_W       = CROSS_W - SPLIT_W;
   localparam int LO_PROD_W  = COORD_W + SPLIT_W + 1;
   localparam int HI_PROD_W  = COORD_W + HI_W;
   localparam int TERM_W     = COORD_W + CROSS_W;
   localparam int FULL_W     = TERM_W + 1;
   localparam int DEN_FULL_W = CROSS_W + 1;
   localparam int KEY_W      = 2 * COORD_W;

   // Result field widths.
   localparam int CNT_W = 2;
   localparam int NUM_W = 52;
   localparam int DEN_W = 37;

   // Endpoint indexes.
   localparam int NUM_PTS = 4;
   localparam int PT_A    = 0;
   localparam int PT_B    = 1;
   localparam int PT_C    = 2;
   localparam int PT_D    = 3;

   // Difference vector pairs: four orientation tests, then one on-segment
   // test per endpoint (A, B, C, D in that order).
   localparam int NUM_PAIRS = 8;
   localparam int PR_ACD    = 0;
   localparam int PR_BCD    = 1;
   localparam int PR_CAB    = 2;
   localparam int PR_DAB    = 3;
   localparam int PR_ON     = 4;

   // Numerator terms of the crossing point.
   localparam int NUM_TERMS = 4;
   localparam int TM_AX     = 0;
   localparam int TM_BX     = 1;
   localparam int TM_AY     = 2;
   localparam int TM_BY     = 3;

   typedef logic signed [COORD_W-1:0]    coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [CROSS_W-1:0]    cross_type;
   typedef logic signed [SPLIT_W:0]      lo_op_type;
   typedef logic signed [HI_W-1:0]       hi_op_type;
   typedef logic signed [LO_PROD_W-1:0]  lo_prod_type;
   typedef logic signed [HI_PROD_W-1:0]  hi_prod_type;
   typedef logic signed [TERM_W-1:0]     term_type;
   typedef logic signed [FULL_W-1:0]     full_type;
   typedef logic signed [DEN_FULL_W-1:0] den_raw_type;
   typedef logic [DEN_FULL_W-1:0]        den_mag_type;
   typedef logic [KEY_W-1:0]             key_type;
   typedef logic [CNT_W-1:0]             cnt_type;
   typedef logic signed [NUM_W-1:0]      num_type;
   typedef logic [DEN_W-1:0]             den_type;

   typedef struct packed {
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by_coord;
      coord_type cx;
      coord_type cy;
      coord_type dx;
      coord_type dy;
   } req_type;

   typedef struct packed {
      cnt_type point_count;
      num_type x_numerator;
      num_type y_numerator;
      den_type denominator;
      logic    last;
   } rsp_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      diff_type x;
      diff_type y;
   } vec_type;

   typedef struct packed {
      point_type [NUM_PTS-1:0] pt;
      vec_type [NUM_PAIRS-1:0] u;
      vec_type [NUM_PAIRS-1:0] v;
   } diff_stage_type;

   typedef struct packed {
      point_type [NUM_PTS-1:0] pt;
      prod_type [NUM_PAIRS-1:0] cl;
      prod_type [NUM_PAIRS-1:0] cr;
      prod_type [NUM_PTS-1:0]   dp;
      prod_type [NUM_PTS-1:0]   dq;
   } prod_stage_type;

   typedef struct packed {
      point_type [NUM_PTS-1:0]          pt;
      cross_type                        acd;
      cross_type                        bcd;
      logic                             proper;
      logic [NUM_PTS-1:0]               on;
      logic [NUM_PTS-1:0][NUM_PTS-1:0] lt;
   } class_stage_type;

   typedef struct packed {
      logic                             proper;
      cnt_type                          cnt;
      point_type                        p0;
      point_type                        p1;
      lo_prod_type [NUM_TERMS-1:0]      lo;
      hi_prod_type [NUM_TERMS-1:0]      hi;
      den_raw_type                      den_raw;
   } pick_stage_type;

   typedef struct packed {
      logic                     proper;
      logic                     neg;
      cnt_type                  cnt;
      point_type                p0;
      point_type                p1;
      term_type [NUM_TERMS-1:0] t;
      den_mag_type              den;
   } sum_stage_type;

   typedef struct packed {
      logic        proper;
      cnt_type     cnt;
      point_type   p0;
      point_type   p1;
      full_type    xn;
      full_type    yn;
      den_mag_type den;
   } out_stage_type;

   function automatic vec_type diff_vec(point_type p, point_type q);
      vec_type r;
      r.x = diff_type'(p.x) - diff_type'(q.x);
      r.y = diff_type'(p.y) - diff_type'(q.y);
      return r;
   endfunction

   // Unsigned key whose order is ascending x, then ascending y.
   function automatic key_type pt_key(point_type p);
      return {~p.x[COORD_W-1], p.x[COORD_W-2:0], ~p.y[COORD_W-1], p.y[COORD_W-2:0]};
   endfunction

endpackage

FILE: rtl/sip_front.sv
// ----------------------------------------------------------------------------
// sip_front
// Two pipeline stages: endpoint differences, then every product needed by
// the orientation and on-segment tests.
// ----------------------------------------------------------------------------
module sip_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  sip_pkg::req_type        in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output sip_pkg::prod_stage_type out_item
);

   logic                    s1_v_ff, s1_v_in, s1_adv;
   sip_pkg::diff_stage_type s1_ff, s1_in;
   logic                    s2_v_ff, s2_v_in, s2_adv;
   sip_pkg::prod_stage_type s2_ff, s2_in;
   sip_pkg::point_type      pa, pb, pc, pd;

   assign s2_adv   = !s2_v_ff || out_ready;
   assign s1_adv   = !s1_v_ff || s2_adv;
   assign in_ready = s1_adv;
   assign s1_v_in  = s1_adv ? in_valid : s1_v_ff;
   assign s2_v_in  = s2_adv ? s1_v_ff : s2_v_ff;

   assign pa = '{x: in_item.ax, y: in_item.ay};
   assign pb = '{x: in_item.bx, y: in_item.by_coord};
   assign pc = '{x: in_item.cx, y: in_item.cy};
   assign pd = '{x: in_item.dx, y: in_item.dy};

   always_comb begin
      s1_in.pt[sip_pkg::PT_A] = pa;
      s1_in.pt[sip_pkg::PT_B] = pb;
      s1_in.pt[sip_pkg::PT_C] = pc;
      s1_in.pt[sip_pkg::PT_D] = pd;
      s1_in.u[sip_pkg::PR_ACD] = sip_pkg::diff_vec(pc, pa);
      s1_in.v[sip_pkg::PR_ACD] = sip_pkg::diff_vec(pd, pc);
      s1_in.u[sip_pkg::PR_BCD] = sip_pkg::diff_vec(pc, pb);
      s1_in.v[sip_pkg::PR_BCD] = sip_pkg::diff_vec(pd, pc);
      s1_in.u[sip_pkg::PR_CAB] = sip_pkg::diff_vec(pa, pc);
      s1_in.v[sip_pkg::PR_CAB] = sip_pkg::diff_vec(pb, pa);
      s1_in.u[sip_pkg::PR_DAB] = sip_pkg::diff_vec(pa, pd);
      s1_in.v[sip_pkg::PR_DAB] = sip_pkg::diff_vec(pb, pa);
      // Endpoint q on segment s-e: u = s - q, v = e - q.
      s1_in.u[sip_pkg::PR_ON + sip_pkg::PT_A] = sip_pkg::diff_vec(pc, pa);
      s1_in.v[sip_pkg::PR_ON + sip_pkg::PT_A] = sip_pkg::diff_vec(pd, pa);
      s1_in.u[sip_pkg::PR_ON + sip_pkg::PT_B] = sip_pkg::diff_vec(pc, pb);
      s1_in.v[sip_pkg::PR_ON + sip_pkg::PT_B] = sip_pkg::diff_vec(pd, pb);
      s1_in.u[sip_pkg::PR_ON + sip_pkg::PT_C] = sip_pkg::diff_vec(pa, pc);
      s1_in.v[sip_pkg::PR_ON + sip_pkg::PT_C] = sip_pkg::diff_vec(pb, pc);
      s1_in.u[sip_pkg::PR_ON + sip_pkg::PT_D] = sip_pkg::diff_vec(pa, pd);
      s1_in.v[sip_pkg::PR_ON + sip_pkg::PT_D] = sip_pkg::diff_vec(pb, pd);
   end

   always_comb begin
      s2_in.pt = s1_ff.pt;
      for (int i = 0; i < sip_pkg::NUM_PAIRS; i++) begin
         s2_in.cl[i] = s1_ff.u[i].x * s1_ff.v[i].y;
         s2_in.cr[i] = s1_ff.u[i].y * s1_ff.v[i].x;
      end
      for (int j = 0; j < sip_pkg::NUM_PTS; j++) begin
         s2_in.dp[j] = s1_ff.u[sip_pkg::PR_ON + j].x * s1_ff.v[sip_pkg::PR_ON + j].x;
         s2_in.dq[j] = s1_ff.u[sip_pkg::PR_ON + j].y * s1_ff.v[sip_pkg::PR_ON + j].y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && in_valid) begin
         s1_ff <= s1_in;
      end
      if (s2_adv && s1_v_ff) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_v_ff;
   assign out_item  = s2_ff;

endmodule

FILE: rtl/sip_classify.sv
// ----------------------------------------------------------------------------
// sip_classify
// Two pipeline stages: cross products, crossing and on-segment flags and
// endpoint order; then endpoint selection and the split numerator products.
// ----------------------------------------------------------------------------
module sip_classify (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  sip_pkg::prod_stage_type in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output sip_pkg::pick_stage_type out_item
);

   logic                     s3_v_ff, s3_v_in, s3_adv;
   sip_pkg::class_stage_type s3_ff, s3_in;
   logic                     s4_v_ff, s4_v_in, s4_adv;
   sip_pkg::pick_stage_type  s4_ff, s4_in;

   assign s4_adv   = !s4_v_ff || out_ready;
   assign s3_adv   = !s3_v_ff || s4_adv;
   assign in_ready = s3_adv;
   assign s3_v_in  = s3_adv ? in_valid : s3_v_ff;
   assign s4_v_in  = s4_adv ? s3_v_ff : s4_v_ff;

   always_comb begin
      sip_pkg::cross_type cx [sip_pkg::NUM_PAIRS];
      sip_pkg::cross_type dt [sip_pkg::NUM_PTS];
      logic               cd_split, ab_split;
      for (int i = 0; i < sip_pkg::NUM_PAIRS; i++) begin
         cx[i] = sip_pkg::cross_type'(in_item.cl[i]) - sip_pkg::cross_type'(in_item.cr[i]);
      end
      for (int j = 0; j < sip_pkg::NUM_PTS; j++) begin
         dt[j] = sip_pkg::cross_type'(in_item.dp[j]) + sip_pkg::cross_type'(in_item.dq[j]);
         s3_in.on[j] = (cx[sip_pkg::PR_ON + j] == '0) &&
                       (dt[j][sip_pkg::CROSS_W-1] || (dt[j] == '0));
      end
      // Strict opposite sides: both nonzero with different signs.
      cd_split = (cx[sip_pkg::PR_ACD] != '0) && (cx[sip_pkg::PR_BCD] != '0) &&
                 (cx[sip_pkg::PR_ACD][sip_pkg::CROSS_W-1] ^
                  cx[sip_pkg::PR_BCD][sip_pkg::CROSS_W-1]);
      ab_split = (cx[sip_pkg::PR_CAB] != '0) && (cx[sip_pkg::PR_DAB] != '0) &&
                 (cx[sip_pkg::PR_CAB][sip_pkg::CROSS_W-1] ^
                  cx[sip_pkg::PR_DAB][sip_pkg::CROSS_W-1]);
      s3_in.proper = cd_split && ab_split;
      s3_in.acd    = cx[sip_pkg::PR_ACD];
      s3_in.bcd    = cx[sip_pkg::PR_BCD];
      s3_in.pt     = in_item.pt;
      for (int i = 0; i < sip_pkg::NUM_PTS; i++) begin
         for (int j = 0; j < sip_pkg::NUM_PTS; j++) begin
            s3_in.lt[i][j] = sip_pkg::pt_key(in_item.pt[i]) < sip_pkg::pt_key(in_item.pt[j]);
         end
      end
   end

   always_comb begin
      logic [sip_pkg::NUM_PTS-1:0] min0, first, cand, min1, second;
      logic                        found0, found1;
      sip_pkg::lo_op_type          acd_lo, bcd_lo;
      sip_pkg::hi_op_type          acd_hi, bcd_hi;
      // Smallest flagged endpoint, lowest index on a tie.
      min0 = s3_ff.on;
      for (int i = 0; i < sip_pkg::NUM_PTS; i++) begin
         for (int j = 0; j < sip_pkg::NUM_PTS; j++) begin
            if (s3_ff.on[j] && s3_ff.lt[j][i]) begin
               min0[i] = 1'b0;
            end
         end
      end
      first  = '0;
      found0 = 1'b0;
      for (int i = 0; i < sip_pkg::NUM_PTS; i++) begin
         if (min0[i] && !found0) begin
            first[i] = 1'b1;
            found0   = 1'b1;
         end
      end
      // Flagged endpoints strictly above the first one; duplicates drop out.
      cand = '0;
      for (int i = 0; i < sip_pkg::NUM_PTS; i++) begin
         for (int j = 0; j < sip_pkg::NUM_PTS; j++) begin
            if (first[i] && s3_ff.on[j] && s3_ff.lt[i][j]) begin
               cand[j] = 1'b1;
            end
         end
      end
      min1 = cand;
      for (int i = 0; i < sip_pkg::NUM_PTS; i++) begin
         for (int j = 0; j < sip_pkg::NUM_PTS; j++) begin
            if (cand[j] && s3_ff.lt[j][i]) begin
               min1[i] = 1'b0;
            end
         end
      end
      second = '0;
      found1 = 1'b0;
      for (int i = 0; i < sip_pkg::NUM_PTS; i++) begin
         if (min1[i] && !found1) begin
            second[i] = 1'b1;
            found1    = 1'b1;
         end
      end
      s4_in.p0 = '0;
      s4_in.p1 = '0;
      for (int i = 0; i < sip_pkg::NUM_PTS; i++) begin
         if (first[i]) begin
            s4_in.p0 = s3_ff.pt[i];
         end
         if (second[i]) begin
            s4_in.p1 = s3_ff.pt[i];
         end
      end
      if (!found0) begin
         s4_in.cnt = sip_pkg::cnt_type'(0);
      end else if (found1) begin
         s4_in.cnt = sip_pkg::cnt_type'(2);
      end else begin
         s4_in.cnt = sip_pkg::cnt_type'(1);
      end
      s4_in.proper = s3_ff.proper;

      // Coordinate times cross product, cut into a low and a high half.
      acd_lo = sip_pkg::lo_op_type'({1'b0, s3_ff.acd[sip_pkg::SPLIT_W-1:0]});
      bcd_lo = sip_pkg::lo_op_type'({1'b0, s3_ff.bcd[sip_pkg::SPLIT_W-1:0]});
      acd_hi = sip_pkg::hi_op_type'(s3_ff.acd[sip_pkg::CROSS_W-1:sip_pkg::SPLIT_W]);
      bcd_hi = sip_pkg::hi_op_type'(s3_ff.bcd[sip_pkg::CROSS_W-1:sip_pkg::SPLIT_W]);
      s4_in.lo[sip_pkg::TM_AX] = s3_ff.pt[sip_pkg::PT_A].x * bcd_lo;
      s4_in.hi[sip_pkg::TM_AX] = s3_ff.pt[sip_pkg::PT_A].x * bcd_hi;
      s4_in.lo[sip_pkg::TM_BX] = s3_ff.pt[sip_pkg::PT_B].x * acd_lo;
      s4_in.hi[sip_pkg::TM_BX] = s3_ff.pt[sip_pkg::PT_B].x * acd_hi;
      s4_in.lo[sip_pkg::TM_AY] = s3_ff.pt[sip_pkg::PT_A].y * bcd_lo;
      s4_in.hi[sip_pkg::TM_AY] = s3_ff.pt[sip_pkg::PT_A].y * bcd_hi;
      s4_in.lo[sip_pkg::TM_BY] = s3_ff.pt[sip_pkg::PT_B].y * acd_lo;
      s4_in.hi[sip_pkg::TM_BY] = s3_ff.pt[sip_pkg::PT_B].y * acd_hi;
      s4_in.den_raw = sip_pkg::den_raw_type'(s3_ff.bcd) - sip_pkg::den_raw_type'(s3_ff.acd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= s3_v_in;
         s4_v_ff <= s4_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_adv && in_valid) begin
         s3_ff <= s3_in;
      end
      if (s4_adv && s3_v_ff) begin
         s4_ff <= s4_in;
      end
   end

   assign out_valid = s4_v_ff;
   assign out_item  = s4_ff;

endmodule

FILE: rtl/sip_finish.sv
// ----------------------------------------------------------------------------
// sip_finish
// Joins the split products and takes the magnitude of the denominator, forms
// the signed numerators, and sends one or two result beats per item.
// ----------------------------------------------------------------------------
module sip_finish (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  sip_pkg::pick_stage_type in_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output sip_pkg::rsp_type        rsp_payload
);

   logic                   s5_v_ff, s5_v_in, s5_adv;
   sip_pkg::sum_stage_type s5_ff, s5_in;
   logic                   out_v_ff, out_v_in, out_free, out_load;
   logic                   beat_ff, beat_in;
   sip_pkg::out_stage_type out_ff, out_in;
   logic                   two_beats, last_beat;
   sip_pkg::point_type     cur_pt;

   assign two_beats = !out_ff.proper && (out_ff.cnt == sip_pkg::cnt_type'(2));
   assign last_beat = !two_beats || beat_ff;
   assign out_free  = !out_v_ff || (rsp_ready && last_beat);
   assign out_load  = out_free && s5_v_ff;
   assign s5_adv    = !s5_v_ff || out_free;
   assign in_ready  = s5_adv;
   assign s5_v_in   = s5_adv ? in_valid : s5_v_ff;
   assign out_v_in  = out_free ? s5_v_ff : out_v_ff;

   always_comb begin
      if (out_load) begin
         beat_in = 1'b0;
      end else if (out_v_ff && rsp_ready && !last_beat) begin
         beat_in = 1'b1;
      end else begin
         beat_in = beat_ff;
      end
   end

   always_comb begin
      s5_in.proper = in_item.proper;
      s5_in.cnt    = in_item.cnt;
      s5_in.p0     = in_item.p0;
      s5_in.p1     = in_item.p1;
      for (int k = 0; k < sip_pkg::NUM_TERMS; k++) begin
         s5_in.t[k] = (sip_pkg::term_type'(in_item.hi[k]) <<< sip_pkg::SPLIT_W) +
                      sip_pkg::term_type'(in_item.lo[k]);
      end
      s5_in.neg = in_item.den_raw[sip_pkg::DEN_FULL_W-1];
      if (s5_in.neg) begin
         s5_in.den = sip_pkg::den_mag_type'(-in_item.den_raw);
      end else begin
         s5_in.den = sip_pkg::den_mag_type'(in_item.den_raw);
      end
   end

   always_comb begin
      out_in.proper = s5_ff.proper;
      out_in.cnt    = s5_ff.cnt;
      out_in.p0     = s5_ff.p0;
      out_in.p1     = s5_ff.p1;
      out_in.den    = s5_ff.den;
      // A negative denominator flips the sign of both numerators.
      if (s5_ff.neg) begin
         out_in.xn = sip_pkg::full_type'(s5_ff.t[sip_pkg::TM_BX]) -
                     sip_pkg::full_type'(s5_ff.t[sip_pkg::TM_AX]);
         out_in.yn = sip_pkg::full_type'(s5_ff.t[sip_pkg::TM_BY]) -
                     sip_pkg::full_type'(s5_ff.t[sip_pkg::TM_AY]);
      end else begin
         out_in.xn = sip_pkg::full_type'(s5_ff.t[sip_pkg::TM_AX]) -
                     sip_pkg::full_type'(s5_ff.t[sip_pkg::TM_BX]);
         out_in.yn = sip_pkg::full_type'(s5_ff.t[sip_pkg::TM_AY]) -
                     sip_pkg::full_type'(s5_ff.t[sip_pkg::TM_BY]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         beat_ff  <= 1'b0;
      end else begin
         s5_v_ff  <= s5_v_in;
         out_v_ff <= out_v_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_adv && in_valid) begin
         s5_ff <= s5_in;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign cur_pt = beat_ff ? out_ff.p1 : out_ff.p0;

   always_comb begin
      rsp_payload.point_count = '0;
      rsp_payload.x_numerator = '0;
      rsp_payload.y_numerator = '0;
      rsp_payload.denominator = '0;
      rsp_payload.last        = 1'b1;
      if (out_ff.proper) begin
         rsp_payload.point_count = sip_pkg::cnt_type'(1);
         rsp_payload.x_numerator = sip_pkg::num_type'(out_ff.xn);
         rsp_payload.y_numerator = sip_pkg::num_type'(out_ff.yn);
         rsp_payload.denominator = sip_pkg::den_type'(out_ff.den);
      end else if (out_ff.cnt != '0) begin
         rsp_payload.point_count = out_ff.cnt;
         rsp_payload.x_numerator = sip_pkg::num_type'(cur_pt.x);
         rsp_payload.y_numerator = sip_pkg::num_type'(cur_pt.y);
         rsp_payload.denominator = sip_pkg::den_type'(1);
         rsp_payload.last        = last_beat;
      end
   end

   assign rsp_valid = out_v_ff;

endmodule

FILE: rtl/segment_intersection_points_unit.sv
// ----------------------------------------------------------------------------
// segment_intersection_points_unit: exact intersection of two closed segments
// Throughput: one request per cycle unless stalled; two beats for two points.
// Reset: synchronous; it clears all valid bits, the pipeline starts empty.
// ----------------------------------------------------------------------------
//
// The work runs through six register stages, each with its own valid bit:
//   1. endpoint differences for four orientation tests and four on-segment
//      tests;
//   2. all products of those differences (one narrow multiplier each);
//   3. cross and dot products, the proper-crossing flag, the on-segment
//      flags and a full less-than matrix over the four endpoints;
//   4. selection of the two smallest distinct endpoints, the signed
//      denominator and the numerator products, each cut in two halves so
//      that no multiplier grows past a coordinate times half a cross product;
//   5. joining of the halves and the denominator magnitude;
//   6. the output register, which forms the signed numerators.
// A stage takes a new beat whenever it is empty or its own beat moves on, so
// a stall on the result side holds every beat in place without loss.
//
// The output register gives a crossing point as a rational number over a
// positive denominator, and endpoints on the other segment as integers with
// denominator one, in ascending x then y order. When there is no common
// point, a single beat with a point count of zero is sent. The rate is set by
// the single result port: a request with two points holds it for two beats.
module segment_intersection_points_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sip_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sip_pkg::rsp_type rsp_payload
);

   logic                    front_valid, front_ready;
   sip_pkg::prod_stage_type front_item;
   logic                    pick_valid, pick_ready;
   sip_pkg::pick_stage_type pick_item;

   // Stages one and two: differences and products.
   sip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_payload),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   // Stages three and four: classification and endpoint selection.
   sip_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (pick_valid),
      .out_ready (pick_ready),
      .out_item  (pick_item)
   );

   // Stages five and six: numerators, denominator and result beats.
   sip_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (pick_valid),
      .in_ready    (pick_ready),
      .in_item     (pick_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/sip_checker.sv
// ----------------------------------------------------------------------------
// sip_checker
// Port-level checks on the result beats of the segment intersection unit.
// ----------------------------------------------------------------------------
module sip_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sip_pkg::rsp_type rsp_payload
);

   // A stalled result beat stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   // An empty result is a single zeroed beat.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.point_count == '0) |->
         rsp_payload.last && (rsp_payload.x_numerator == '0) &&
         (rsp_payload.y_numerator == '0) && (rsp_payload.denominator == '0))
      else $error("empty result is not a single zero beat");

   // Any point carries a nonzero denominator and a count of at most two.
   a_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.point_count != '0) |->
         (rsp_payload.denominator != '0) && (rsp_payload.point_count != 2'd3))
      else $error("point without denominator or count out of range");

   // Only the first of two endpoint beats lacks the last flag.
   a_first_of_two: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |->
         (rsp_payload.point_count == 2'd2) && (rsp_payload.denominator == 37'd1))
      else $error("non-final beat is not the first of two endpoints");

   // The second endpoint beat follows at once and closes the item.
   a_second_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last |=>
         rsp_valid && rsp_payload.last && (rsp_payload.point_count == 2'd2))
      else $error("second endpoint beat missing");

endmodule

bind segment_intersection_points_unit sip_checker u_sip_checker (.*);

FILE: sim/tb_segment_intersection_points_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_intersection_points_unit
// Self-checking bench for the segment intersection unit. A predictor works out
// the crossing point or the shared endpoints of every accepted request beat.
// Each result beat is checked field by field against the oldest prediction,
// under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_segment_intersection_points_unit;

   // Pacing patterns used by the stimulus. Each queued segment pair carries
   // the pattern under which it is offered, and the receiver follows the
   // pattern of the pair that was offered last.
   typedef enum int {
      PH_STEADY,
      PH_SENDER_IDLE,
      PH_RECEIVER_STALL,
      PH_BOTH
   } pace_type;

   typedef struct {
      sip_pkg::req_type seg;
      pace_type         pace;
      bit               hold_rsp;   // receiver holds off for a long stretch
      bit               wait_drain; // sender waits until every result has come back
   } stim_type;

   localparam int RANDOM_ITEMS  = 1950;
   localparam int RANDOM_BLOCKS = 12;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 20;
   localparam int STUCK_LIMIT   = 4000;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   sip_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   sip_pkg::rsp_type rsp_payload;

   stim_type         pending_segments[$];
   sip_pkg::rsp_type expected_points[$];

   int rsp_stall_pct = 0;
   int hold_events   = 0;
   int holds_seen    = 0;
   int hold_left     = 0;
   int stuck_cycles  = 0;
   int fault_count   = 0;

   segment_intersection_points_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int send_gap_pct(pace_type p);
      return (p == PH_SENDER_IDLE) ? 79 : (p == PH_BOTH) ? 31 : 0;
   endfunction

   function automatic int stall_pct(pace_type p);
      return (p == PH_RECEIVER_STALL) ? 79 : (p == PH_BOTH) ? 31 : 0;
   endfunction

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // A point q lies on the closed segment s..e when the vectors from q to both
   // ends are collinear and point in opposite directions (or one is zero).
   function automatic bit seg_holds_point(longint s_x, longint s_y, longint e_x,
                                          longint e_y, longint q_x, longint q_y);
      longint ux, uy, vx, vy;
      ux = s_x - q_x;
      uy = s_y - q_y;
      vx = e_x - q_x;
      vy = e_y - q_y;
      return (ux * vy - uy * vx == 0) && (ux * vx + uy * vy <= 0);
   endfunction

   // Works out the result beats of one segment pair and queues them. All the
   // arithmetic is exact in 64 bits: cross products need about 35 bits and the
   // numerators about 52.
   function automatic void predict_intersection(sip_pkg::req_type s);
      longint ax, ay, bx, by_c, cx, cy, dx, dy;
      longint acd, bcd, cab, dab, den, xn, yn, tx, ty;
      longint px[4], py[4];
      int     n, cnt, i, j;
      sip_pkg::rsp_type r;
      ax   = s.ax;
      ay   = s.ay;
      bx   = s.bx;
      by_c = s.by_coord;
      cx   = s.cx;
      cy   = s.cy;
      dx   = s.dx;
      dy   = s.dy;

      // Orientation of each endpoint against the line through the other pair.
      acd = (cx - ax) * (dy - cy) - (cy - ay) * (dx - cx);
      bcd = (cx - bx) * (dy - cy) - (cy - by_c) * (dx - cx);
      cab = (ax - cx) * (by_c - ay) - (ay - cy) * (bx - ax);
      dab = (ax - dx) * (by_c - ay) - (ay - dy) * (bx - ax);

      if (((acd > 0 && bcd < 0) || (acd < 0 && bcd > 0)) &&
          ((cab > 0 && dab < 0) || (cab < 0 && dab > 0))) begin
         // Proper crossing: one unreduced rational point, positive divisor.
         den = bcd - acd;
         xn  = ax * bcd - bx * acd;
         yn  = ay * bcd - by_c * acd;
         if (den < 0) begin
            den = -den;
            xn  = -xn;
            yn  = -yn;
         end
         r.point_count = sip_pkg::cnt_type'(1);
         r.x_numerator = sip_pkg::num_type'(xn);
         r.y_numerator = sip_pkg::num_type'(yn);
         r.denominator = sip_pkg::den_type'(den);
         r.last        = 1'b1;
         expected_points.push_back(r);
         return;
      end

      // Otherwise gather the endpoints that touch the other segment.
      n = 0;
      if (seg_holds_point(cx, cy, dx, dy, ax, ay)) begin
         px[n] = ax;
         py[n] = ay;
         n++;
      end
      if (seg_holds_point(cx, cy, dx, dy, bx, by_c)) begin
         px[n] = bx;
         py[n] = by_c;
         n++;
      end
      if (seg_holds_point(ax, ay, bx, by_c, cx, cy)) begin
         px[n] = cx;
         py[n] = cy;
         n++;
      end
      if (seg_holds_point(ax, ay, bx, by_c, dx, dy)) begin
         px[n] = dx;
         py[n] = dy;
         n++;
      end

      // Order by x, then y, and keep each distinct point once.
      for (i = 1; i < n; i++) begin
         tx = px[i];
         ty = py[i];
         j  = i - 1;
         while (j >= 0 && (tx < px[j] || (tx == px[j] && ty < py[j]))) begin
            px[j + 1] = px[j];
            py[j + 1] = py[j];
            j--;
         end
         px[j + 1] = tx;
         py[j + 1] = ty;
      end
      cnt = 0;
      for (i = 0; i < n; i++) begin
         if (cnt == 0 || px[cnt - 1] != px[i] || py[cnt - 1] != py[i]) begin
            px[cnt] = px[i];
            py[cnt] = py[i];
            cnt++;
         end
      end
      if (cnt > 2) cnt = 2;

      if (cnt == 0) begin
         r = '0;
         r.last = 1'b1;
         expected_points.push_back(r);
      end else begin
         for (i = 0; i < cnt; i++) begin
            r.point_count = sip_pkg::cnt_type'(cnt);
            r.x_numerator = sip_pkg::num_type'(px[i]);
            r.y_numerator = sip_pkg::num_type'(py[i]);
            r.denominator = sip_pkg::den_type'(1);
            r.last        = (i == cnt - 1);
            expected_points.push_back(r);
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------------

   function automatic int pick(int lo, int hi);
      return int'($urandom_range(hi - lo)) + lo;
   endfunction

   function automatic sip_pkg::req_type make_seg(int a_x, int a_y, int b_x, int b_y,
                                                 int c_x, int c_y, int d_x, int d_y);
      sip_pkg::req_type s;
      s.ax       = sip_pkg::coord_type'(a_x);
      s.ay       = sip_pkg::coord_type'(a_y);
      s.bx       = sip_pkg::coord_type'(b_x);
      s.by_coord = sip_pkg::coord_type'(b_y);
      s.cx       = sip_pkg::coord_type'(c_x);
      s.cy       = sip_pkg::coord_type'(c_y);
      s.dx       = sip_pkg::coord_type'(d_x);
      s.dy       = sip_pkg::coord_type'(d_y);
      return s;
   endfunction

   function automatic int extreme_coord();
      case ($urandom_range(5))
         0:       return -32768;
         1:       return 32767;
         2:       return 0;
         3:       return -1;
         4:       return 1;
         default: return pick(-32768, 32767);
      endcase
   endfunction

   // One random segment pair. Most pairs are built to hit the interesting
   // geometry: collinear overlaps, touching endpoints, T-junctions and
   // degenerate segments. The rest are plain noise and extreme coordinates.
   function automatic sip_pkg::req_type random_segments();
      int a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y;
      int p_x, p_y, u_x, u_y, m, k, kind, t0, t1, t2, t3, tmp;
      kind = $urandom_range(99);
      if (kind < 15) begin
         a_x = pick(-32768, 32767);
         a_y = pick(-32768, 32767);
         b_x = pick(-32768, 32767);
         b_y = pick(-32768, 32767);
         c_x = pick(-32768, 32767);
         c_y = pick(-32768, 32767);
         d_x = pick(-32768, 32767);
         d_y = pick(-32768, 32767);
      end else if (kind < 35) begin
         // A tiny grid makes every coincidence common.
         a_x = pick(-3, 3);
         a_y = pick(-3, 3);
         b_x = pick(-3, 3);
         b_y = pick(-3, 3);
         c_x = pick(-3, 3);
         c_y = pick(-3, 3);
         d_x = pick(-3, 3);
         d_y = pick(-3, 3);
      end else if (kind < 60) begin
         // All four points on one line, at random steps along it.
         p_x = pick(-20000, 20000);
         p_y = pick(-20000, 20000);
         u_x = pick(-40, 40);
         u_y = pick(-40, 40);
         t0  = pick(-300, 300);
         t1  = pick(-300, 300);
         t2  = pick(-300, 300);
         t3  = pick(-300, 300);
         if ($urandom_range(3) == 0) t2 = $urandom_range(1) ? t0 : t1;
         a_x = p_x + t0 * u_x;
         a_y = p_y + t0 * u_y;
         b_x = p_x + t1 * u_x;
         b_y = p_y + t1 * u_y;
         c_x = p_x + t2 * u_x;
         c_y = p_y + t2 * u_y;
         d_x = p_x + t3 * u_x;
         d_y = p_y + t3 * u_y;
      end else begin
         // C sits on AB (at an end or inside), D goes anywhere nearby.
         a_x = pick(-20000, 20000);
         a_y = pick(-20000, 20000);
         u_x = pick(-40, 40);
         u_y = pick(-40, 40);
         m   = pick(1, 50);
         k   = $urandom_range(1) ? 0 : pick(0, m);
         b_x = a_x + m * u_x;
         b_y = a_y + m * u_y;
         c_x = a_x + k * u_x;
         c_y = a_y + k * u_y;
         d_x = c_x + pick(-2000, 2000);
         d_y = c_y + pick(-2000, 2000);
         if (kind >= 80 && kind < 90) begin
            // Collapse one or both segments to a single point.
            case ($urandom_range(2))
               0: begin
                  d_x = c_x;
                  d_y = c_y;
               end
               1: begin
                  b_x = a_x;
                  b_y = a_y;
                  c_x = a_x;
                  c_y = a_y;
               end
               default: begin
                  b_x = a_x;
                  b_y = a_y;
                  d_x = c_x;
                  d_y = c_y;
               end
            endcase
         end else if (kind >= 90) begin
            a_x = extreme_coord();
            a_y = extreme_coord();
            b_x = extreme_coord();
            b_y = extreme_coord();
            c_x = extreme_coord();
            c_y = extreme_coord();
            d_x = extreme_coord();
            d_y = extreme_coord();
         end
      end

      // Shuffle endpoint order and segment roles so every position is tried.
      if ($urandom_range(1)) begin
         tmp = a_x; a_x = b_x; b_x = tmp;
         tmp = a_y; a_y = b_y; b_y = tmp;
      end
      if ($urandom_range(1)) begin
         tmp = c_x; c_x = d_x; d_x = tmp;
         tmp = c_y; c_y = d_y; d_y = tmp;
      end
      if ($urandom_range(1)) begin
         tmp = a_x; a_x = c_x; c_x = tmp;
         tmp = a_y; a_y = c_y; c_y = tmp;
         tmp = b_x; b_x = d_x; d_x = tmp;
         tmp = b_y; b_y = d_y; d_y = tmp;
      end
      return make_seg(a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y);
   endfunction

   task automatic queue_seg(sip_pkg::req_type s, pace_type p, bit hold, bit drain);
      stim_type it;
      it.seg        = s;
      it.pace       = p;
      it.hold_rsp   = hold;
      it.wait_drain = drain;
      pending_segments.push_back(it);
   endtask

   // ------------------------------------------------------------------------
   // Request driver. Payload and valid change only at a rising edge, and a
   // pending beat is held until the unit takes it. The beat is predicted at
   // the edge where it is accepted.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      stim_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_intersection(req_payload);
         if (!req_valid || req_ready) begin
            if (pending_segments.size() != 0 &&
                !(pending_segments[0].wait_drain && expected_points.size() != 0) &&
                $urandom_range(99) >= send_gap_pct(pending_segments[0].pace)) begin
               nxt = pending_segments.pop_front();
               req_payload   <= nxt.seg;
               req_valid     <= 1'b1;
               rsp_stall_pct <= stall_pct(nxt.pace);
               // Ask the receiver for a long hold-off; the sender keeps
               // offering beats meanwhile, so the pipeline backs up.
               if (nxt.hold_rsp) hold_events <= hold_events + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fault_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Result monitor and receiver. Every accepted result beat is checked
   // against the oldest prediction; ready is randomized per the current pace,
   // or held low for a long stretch when the driver asks for it.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      sip_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $error("result beat with no prediction waiting: count %0d",
                      rsp_payload.point_count);
               fault_count++;
            end else begin
               want = expected_points.pop_front();
               compare_field("point_count", want.point_count, rsp_payload.point_count);
               compare_field("x_numerator", want.x_numerator, rsp_payload.x_numerator);
               compare_field("y_numerator", want.y_numerator, rsp_payload.y_numerator);
               compare_field("denominator", want.denominator, rsp_payload.denominator);
               compare_field("last", want.last, rsp_payload.last);
            end
         end
         if (holds_seen != hold_events) begin
            holds_seen <= hold_events;
            hold_left  <= HOLD_CYCLES;
            rsp_ready  <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog: cycles in a row in which no beat moved on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : test_sequence
      int       blk, i;
      pace_type p;

      // Directed pairs: crossings, collinear overlaps, touching ends,
      // degenerate segments, misses, and coordinates at both extremes.
      queue_seg(make_seg(0, 0, 4, 4, 0, 4, 4, 0), PH_STEADY, 0, 0);
      queue_seg(make_seg(0, 0, 3, 1, 0, 1, 1, 0), PH_STEADY, 0, 0);
      queue_seg(make_seg(4, 4, 0, 0, 0, 4, 4, 0), PH_STEADY, 0, 0);
      queue_seg(make_seg(0, 0, 4, 0, 0, 1, 4, 1), PH_STEADY, 0, 0);
      queue_seg(make_seg(0, 0, 4, 0, 2, 0, 6, 0), PH_STEADY, 0, 0);
      queue_seg(make_seg(0, 0, 1, 1, 2, 2, 3, 3), PH_STEADY, 0, 0);
      queue_seg(make_seg(0, 0, 2, 2, 2, 2, 5, 5), PH_STEADY, 0, 0);
      queue_seg(make_seg(0, 0, 4, 0, 2, 0, 2, 5), PH_STEADY, 0, 0);
      queue_seg(make_seg(1, 1, 3, 5, 1, 1, -4, 2), PH_STEADY, 0, 0);
      queue_seg(make_seg(-3, 7, 5, -1, -3, 7, 5, -1), PH_STEADY, 0, 0);
      queue_seg(make_seg(-3, 7, 5, -1, 5, -1, -3, 7), PH_STEADY, 0, 0);
      queue_seg(make_seg(0, 0, 10, 0, 3, 0, 5, 0), PH_STEADY, 0, 0);
      queue_seg(make_seg(0, -5, 0, 5, 0, 3, 0, 9), PH_STEADY, 0, 0);
      queue_seg(make_seg(2, 2, 2, 2, 0, 0, 4, 4), PH_STEADY, 0, 0);
      queue_seg(make_seg(2, 3, 2, 3, 0, 0, 4, 4), PH_STEADY, 0, 0);
      queue_seg(make_seg(7, -7, 7, -7, 7, -7, 7, -7), PH_STEADY, 0, 0);
      queue_seg(make_seg(1, 1, 1, 1, 2, 2, 2, 2), PH_STEADY, 0, 0);
      queue_seg(make_seg(0, 0, 4, 0, 5, -1, 5, 1), PH_STEADY, 0, 0);
      queue_seg(make_seg(0, 0, 2, 0, 3, 0, 3, 3), PH_STEADY, 0, 0);
      queue_seg(make_seg(0, 0, 0, 0, 0, 0, 0, 0), PH_STEADY, 0, 0);
      queue_seg(make_seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768),
                PH_STEADY, 0, 0);
      queue_seg(make_seg(32767, -32768, -32768, 32767, -32768, -32767, 32767, 32767),
                PH_STEADY, 0, 0);
      queue_seg(make_seg(-32768, -32768, 32767, -32768, 0, -32768, -32768, -32768),
                PH_STEADY, 0, 0);
      queue_seg(make_seg(-32768, 0, 32767, 0, 0, 0, 0, 32767), PH_STEADY, 0, 0);

      // Random blocks cycle through the pacing patterns. Each block starts
      // only after the previous one has fully drained, and each steady block
      // opens with a long receiver hold-off.
      for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         p = pace_type'(blk % 4);
         for (i = 0; i < RANDOM_ITEMS / RANDOM_BLOCKS; i++) begin
            queue_seg(random_segments(), p, (i == 0 && p == PH_STEADY), (i == 0));
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_segments.size() != 0 || req_valid || expected_points.size() != 0)
      begin
         @(posedge clock);
         if (stuck_cycles >= STUCK_LIMIT) break;
      end

      if (stuck_cycles >= STUCK_LIMIT) begin
         $error("no progress for %0d cycles, %0d results outstanding",
                STUCK_LIMIT, expected_points.size());
         $display("segment_intersection_points_unit: mismatch");
      end else begin
         // Let any stray beat surface before the verdict.
         repeat (SETTLE_CYCLES) @(posedge clock);
         if (expected_points.size() != 0) begin
            $error("%0d predicted results never arrived", expected_points.size());
         end
         if (fault_count == 0 && expected_points.size() == 0) begin
            $display("segment_intersection_points_unit: match");
         end else begin
            $display("segment_intersection_points_unit: mismatch");
         end
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/sip_pkg.sv
rtl/sip_front.sv
rtl/sip_classify.sv
rtl/sip_finish.sv
rtl/segment_intersection_points_unit.sv
rtl/sip_checker.sv
sim/tb_segment_intersection_points_unit.sv
